/* rtl/lbc_pkg.sv */
// Shared types, constants and helper functions for the line clipper.
`default_nettype none
package lbc_pkg;

    localparam int COORD_BITS = 16;
    localparam int NUM_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS + 2;
    localparam int QUO_BITS   = COORD_BITS + 1;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [NUM_BITS-1:0]   num_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_in_t;

    typedef struct packed {
        logic   visible;
        coord_t clip_start_x;
        coord_t clip_start_y;
        coord_t clip_end_x;
        coord_t clip_end_y;
    } seg_out_t;

    typedef struct packed {
        coord_t x_min;
        coord_t x_max;
        coord_t y_min;
        coord_t y_max;
    } window_t;

    // start point and direction, carried alongside the parameter math
    typedef struct packed {
        coord_t x1;
        coord_t y1;
        num_t   dx;
        num_t   dy;
    } ctx_t;

    // per-axis entry/exit fractions, already clamped to [0,1] from one side
    typedef struct packed {
        logic out;
        num_t en;
        num_t ed;
        num_t xn;
        num_t xd;
    } axis_t;

    // classified segment handed from front to back
    typedef struct packed {
        ctx_t ctx;
        num_t n1;
        num_t d1;
        num_t n2;
        num_t d2;
        logic vis;
    } job_t;

    function automatic num_t sx(coord_t v);
        return {v[COORD_BITS-1], v};
    endfunction

    function automatic prod_t mul(num_t a, num_t b);
        prod_t pa;
        prod_t pb;
        pa = prod_t'(a);
        pb = prod_t'(b);
        return pa * pb;
    endfunction

    // d: direction along the axis, ql/qh: distance inside the low/high edge
    function automatic axis_t classify(num_t d, num_t ql, num_t qh);
        axis_t r;
        num_t  ad;
        num_t  en;
        num_t  xn;
        logic  pos;
        pos   = !d[NUM_BITS-1];
        ad    = d[NUM_BITS-1] ? -d : d;
        r.out = (d == '0) && (ql[NUM_BITS-1] || qh[NUM_BITS-1]);
        en    = pos ? -ql : -qh;
        xn    = pos ? qh : ql;
        r.en  = en;
        r.ed  = ad;
        r.xn  = xn;
        r.xd  = ad;
        if (d == '0 || en[NUM_BITS-1])
        begin
            r.en = '0;
            r.ed = num_t'(1);
        end
        if (d == '0 || xn > ad)
        begin
            r.xn = num_t'(1);
            r.xd = num_t'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/lbc_fifo.sv */
// Small register queue used between the front and back and at the result side.
`default_nettype none
module lbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

/* rtl/lbc_front.sv */
// Front end: takes segments, builds boundary terms and picks the entry/exit fractions.
`default_nettype none
module lbc_front
    import lbc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire seg_in_t segment,
    input  wire window_t win,
    output logic         job_push,
    output job_t         job,
    input  wire logic    job_full
);
    localparam int STAGES = 6;

    logic              adv;
    logic              accept;
    logic [STAGES-1:0] vld_reg, vld_next;

    ctx_t  a_ctx_reg, a_ctx_next;
    num_t  a_qxl_reg, a_qxl_next;
    num_t  a_qxh_reg, a_qxh_next;
    num_t  a_qyl_reg, a_qyl_next;
    num_t  a_qyh_reg, a_qyh_next;

    ctx_t  b_ctx_reg, b_ctx_next;
    axis_t b_ax_reg, b_ax_next;
    axis_t b_ay_reg, b_ay_next;
    logic  b_rej_reg, b_rej_next;

    ctx_t  c_ctx_reg, c_ctx_next;
    axis_t c_ax_reg, c_ax_next;
    axis_t c_ay_reg, c_ay_next;
    logic  c_rej_reg, c_rej_next;
    prod_t c_pe_a_reg, c_pe_a_next;
    prod_t c_pe_b_reg, c_pe_b_next;
    prod_t c_px_a_reg, c_px_a_next;
    prod_t c_px_b_reg, c_px_b_next;

    ctx_t  d_ctx_reg, d_ctx_next;
    logic  d_rej_reg, d_rej_next;
    num_t  d_n1_reg, d_n1_next;
    num_t  d_d1_reg, d_d1_next;
    num_t  d_n2_reg, d_n2_next;
    num_t  d_d2_reg, d_d2_next;

    ctx_t  e_ctx_reg, e_ctx_next;
    logic  e_rej_reg, e_rej_next;
    num_t  e_n1_reg, e_n1_next;
    num_t  e_d1_reg, e_d1_next;
    num_t  e_n2_reg, e_n2_next;
    num_t  e_d2_reg, e_d2_next;
    prod_t e_f1_reg, e_f1_next;
    prod_t e_f2_reg, e_f2_next;

    job_t  f_job_reg, f_job_next;

    assign adv      = !(vld_reg[STAGES-1] && job_full);
    assign accept   = push && adv;
    assign full     = !adv;
    assign job_push = vld_reg[STAGES-1] && !job_full;
    assign job      = f_job_reg;
    assign vld_next = {vld_reg[STAGES-2:0], accept};

    always_comb
    begin
        // boundary terms
        a_ctx_next.x1 = segment.start_x;
        a_ctx_next.y1 = segment.start_y;
        a_ctx_next.dx = sx(segment.end_x) - sx(segment.start_x);
        a_ctx_next.dy = sx(segment.end_y) - sx(segment.start_y);
        a_qxl_next    = sx(segment.start_x) - sx(win.x_min);
        a_qxh_next    = sx(win.x_max) - sx(segment.start_x);
        a_qyl_next    = sx(segment.start_y) - sx(win.y_min);
        a_qyh_next    = sx(win.y_max) - sx(segment.start_y);

        // per-axis fractions
        b_ctx_next = a_ctx_reg;
        b_ax_next  = classify(a_ctx_reg.dx, a_qxl_reg, a_qxh_reg);
        b_ay_next  = classify(a_ctx_reg.dy, a_qyl_reg, a_qyh_reg);
        b_rej_next = b_ax_next.out || b_ay_next.out;

        // cross products between the axes
        c_ctx_next  = b_ctx_reg;
        c_ax_next   = b_ax_reg;
        c_ay_next   = b_ay_reg;
        c_rej_next  = b_rej_reg;
        c_pe_a_next = mul(b_ax_reg.en, b_ay_reg.ed);
        c_pe_b_next = mul(b_ay_reg.en, b_ax_reg.ed);
        c_px_a_next = mul(b_ax_reg.xn, b_ay_reg.xd);
        c_px_b_next = mul(b_ay_reg.xn, b_ax_reg.xd);

        // entry is the larger fraction, exit the smaller
        d_ctx_next = c_ctx_reg;
        d_rej_next = c_rej_reg;
        if (c_pe_a_reg >= c_pe_b_reg)
        begin
            d_n1_next = c_ax_reg.en;
            d_d1_next = c_ax_reg.ed;
        end
        else
        begin
            d_n1_next = c_ay_reg.en;
            d_d1_next = c_ay_reg.ed;
        end
        if (c_px_a_reg <= c_px_b_reg)
        begin
            d_n2_next = c_ax_reg.xn;
            d_d2_next = c_ax_reg.xd;
        end
        else
        begin
            d_n2_next = c_ay_reg.xn;
            d_d2_next = c_ay_reg.xd;
        end

        e_ctx_next = d_ctx_reg;
        e_rej_next = d_rej_reg;
        e_n1_next  = d_n1_reg;
        e_d1_next  = d_d1_reg;
        e_n2_next  = d_n2_reg;
        e_d2_next  = d_d2_reg;
        e_f1_next  = mul(d_n1_reg, d_d2_reg);
        e_f2_next  = mul(d_n2_reg, d_d1_reg);

        f_job_next.ctx = e_ctx_reg;
        f_job_next.n1  = e_n1_reg;
        f_job_next.d1  = e_d1_reg;
        f_job_next.n2  = e_n2_reg;
        f_job_next.d2  = e_d2_reg;
        f_job_next.vis = !e_rej_reg && !(e_f1_reg > e_f2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ctx_reg  <= a_ctx_next;
            a_qxl_reg  <= a_qxl_next;
            a_qxh_reg  <= a_qxh_next;
            a_qyl_reg  <= a_qyl_next;
            a_qyh_reg  <= a_qyh_next;
            b_ctx_reg  <= b_ctx_next;
            b_ax_reg   <= b_ax_next;
            b_ay_reg   <= b_ay_next;
            b_rej_reg  <= b_rej_next;
            c_ctx_reg  <= c_ctx_next;
            c_ax_reg   <= c_ax_next;
            c_ay_reg   <= c_ay_next;
            c_rej_reg  <= c_rej_next;
            c_pe_a_reg <= c_pe_a_next;
            c_pe_b_reg <= c_pe_b_next;
            c_px_a_reg <= c_px_a_next;
            c_px_b_reg <= c_px_b_next;
            d_ctx_reg  <= d_ctx_next;
            d_rej_reg  <= d_rej_next;
            d_n1_reg   <= d_n1_next;
            d_d1_reg   <= d_d1_next;
            d_n2_reg   <= d_n2_next;
            d_d2_reg   <= d_d2_next;
            e_ctx_reg  <= e_ctx_next;
            e_rej_reg  <= e_rej_next;
            e_n1_reg   <= e_n1_next;
            e_d1_reg   <= e_d1_next;
            e_n2_reg   <= e_n2_next;
            e_d2_reg   <= e_d2_next;
            e_f1_reg   <= e_f1_next;
            e_f2_reg   <= e_f2_next;
            f_job_reg  <= f_job_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lbc_coord.sv */
// One clipped coordinate: round(base + num/den * delta), pipelined divider one bit per stage.
`default_nettype none
module lbc_coord
    import lbc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire coord_t base,
    input  wire num_t   num,
    input  wire num_t   den,
    input  wire num_t   delta,
    output coord_t      res
);
    localparam int SUM_BITS = PROD_BITS + 1;
    localparam int DVD_BITS = SUM_BITS + 1;
    localparam int DVS_BITS = NUM_BITS + 1;
    localparam int REM_BITS = DVS_BITS + 1;

    prod_t                       pa_reg, pa_next;
    prod_t                       pb_reg, pb_next;
    num_t                        den1_reg, den2_reg, den3_reg;
    logic signed [SUM_BITS-1:0]  sum_reg, sum_next;
    logic        [SUM_BITS-1:0]  mag_reg, mag_next;
    logic                        neg3_reg;
    logic        [DVD_BITS-1:0]  dvd;

    logic [REM_BITS-1:0] rem_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0] low_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS+1];
    logic [DVS_BITS-1:0] dvs_reg [QUO_BITS+1];
    logic                neg_reg [QUO_BITS+1];
    coord_t              res_reg, res_next;

    assign pa_next  = mul(sx(base), den);
    assign pb_next  = mul(num, delta);
    assign sum_next = {pa_reg[PROD_BITS-1], pa_reg} + {pb_reg[PROD_BITS-1], pb_reg};
    assign mag_next = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    // 2*|total| + den, so the floor of the quotient rounds half away from zero
    assign dvd      = {mag_reg, 1'b0} + {{(DVD_BITS - NUM_BITS){1'b0}}, den3_reg};
    assign res_next = neg_reg[QUO_BITS] ? COORD_BITS'(-quo_reg[QUO_BITS])
                                        : COORD_BITS'(quo_reg[QUO_BITS]);
    assign res      = res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            den1_reg   <= den;
            sum_reg    <= sum_next;
            den2_reg   <= den1_reg;
            mag_reg    <= mag_next;
            neg3_reg   <= sum_reg[SUM_BITS-1];
            den3_reg   <= den2_reg;
            rem_reg[0] <= dvd[DVD_BITS-1 -: REM_BITS];
            low_reg[0] <= dvd[QUO_BITS-1:0];
            quo_reg[0] <= '0;
            dvs_reg[0] <= {den3_reg, 1'b0};
            neg_reg[0] <= neg3_reg;
            res_reg    <= res_next;
        end
    end

    for (genvar i = 1; i <= QUO_BITS; i++)
    begin : g_div
        logic [REM_BITS-1:0] cand;
        logic [REM_BITS-1:0] dvs_ext;
        logic                ge;

        assign cand    = {rem_reg[i-1][REM_BITS-2:0], low_reg[i-1][QUO_BITS-1]};
        assign dvs_ext = {1'b0, dvs_reg[i-1]};
        assign ge      = (cand >= dvs_ext);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? cand - dvs_ext : cand;
                low_reg[i] <= {low_reg[i-1][QUO_BITS-2:0], 1'b0};
                quo_reg[i] <= {quo_reg[i-1][QUO_BITS-2:0], ge};
                dvs_reg[i] <= dvs_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/lbc_back.sv */
// Back end: computes the four clipped coordinates of a classified segment.
`default_nettype none
module lbc_back
    import lbc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire job_t  job,
    input  wire logic  job_valid,
    output logic       job_pop,
    output seg_out_t   res,
    output logic       res_push,
    input  wire logic  res_full
);
    localparam int STAGES = QUO_BITS + 5;

    logic              adv;
    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] vis_reg, vis_next;
    coord_t            sx_c, sy_c, ex_c, ey_c;
    logic              vis;

    assign adv      = !(vld_reg[STAGES-1] && res_full);
    assign job_pop  = adv && job_valid;
    assign res_push = vld_reg[STAGES-1] && !res_full;
    assign vld_next = {vld_reg[STAGES-2:0], job_pop};
    assign vis_next = {vis_reg[STAGES-2:0], job.vis};
    assign vis      = vis_reg[STAGES-1];

    lbc_coord u_start_x (.clk(clk), .en(adv), .base(job.ctx.x1), .num(job.n1),
                         .den(job.d1), .delta(job.ctx.dx), .res(sx_c));
    lbc_coord u_start_y (.clk(clk), .en(adv), .base(job.ctx.y1), .num(job.n1),
                         .den(job.d1), .delta(job.ctx.dy), .res(sy_c));
    lbc_coord u_end_x   (.clk(clk), .en(adv), .base(job.ctx.x1), .num(job.n2),
                         .den(job.d2), .delta(job.ctx.dx), .res(ex_c));
    lbc_coord u_end_y   (.clk(clk), .en(adv), .base(job.ctx.y1), .num(job.n2),
                         .den(job.d2), .delta(job.ctx.dy), .res(ey_c));

    // rejected segments report all-zero coordinates
    always_comb
    begin
        res.visible      = vis;
        res.clip_start_x = vis ? sx_c : '0;
        res.clip_start_y = vis ? sy_c : '0;
        res.clip_end_x   = vis ? ex_c : '0;
        res.clip_end_y   = vis ? ey_c : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= vis_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/liang_barsky_line_clipper_core.sv */
// Liang-Barsky line clipper: top level with window registers, queues and assertions.
// A pushed segment passes the front end, the middle queue and the back end into the result queue.
// Throughput: one segment per cycle while neither side stalls; the back end divider retires one quotient bit per stage.
// Either side may stall; the queue between front and back absorbs short mismatches.
// Reset clears all queues and pipeline valid bits; window resets to x 0..1023, y 0..1023.
`default_nettype none
module liang_barsky_line_clipper_core
    import lbc_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire seg_in_t              segment,
    output logic                      empty,
    input  wire logic                 pop,
    output seg_out_t                  result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready
);
    window_t  win_reg, win_next;
    coord_t   rd_val;
    logic     cfg_wr;

    logic     mq_push, mq_full, mq_pop, mq_empty;
    job_t     mq_wdata, mq_rdata;
    logic     oq_push, oq_full;
    seg_out_t oq_wdata;
    logic [$bits(job_t)-1:0]     mq_rdata_raw;
    logic [$bits(seg_out_t)-1:0] oq_rdata_raw;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        win_next = win_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_X_MIN: win_next.x_min = pwdata[COORD_BITS-1:0];
                REG_X_MAX: win_next.x_max = pwdata[COORD_BITS-1:0];
                REG_Y_MIN: win_next.y_min = pwdata[COORD_BITS-1:0];
                REG_Y_MAX: win_next.y_max = pwdata[COORD_BITS-1:0];
                default:   win_next = win_reg;
            endcase
        end
        case (paddr[3:2])
            REG_X_MIN: rd_val = win_reg.x_min;
            REG_X_MAX: rd_val = win_reg.x_max;
            REG_Y_MIN: rd_val = win_reg.y_min;
            REG_Y_MAX: rd_val = win_reg.y_max;
            default:   rd_val = '0;
        endcase
        prdata = {{(DATA_BITS - COORD_BITS){rd_val[COORD_BITS-1]}}, rd_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.x_min <= coord_t'(0);
            win_reg.x_max <= coord_t'(1023);
            win_reg.y_min <= coord_t'(0);
            win_reg.y_max <= coord_t'(1023);
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    lbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .segment  (segment),
        .win      (win_reg),
        .job_push (mq_push),
        .job      (mq_wdata),
        .job_full (mq_full)
    );

    lbc_fifo #(.WIDTH($bits(job_t)), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .wdata (mq_wdata),
        .full  (mq_full),
        .pop   (mq_pop),
        .rdata (mq_rdata_raw),
        .empty (mq_empty)
    );

    assign mq_rdata = job_t'(mq_rdata_raw);

    lbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (mq_rdata),
        .job_valid (!mq_empty),
        .job_pop   (mq_pop),
        .res       (oq_wdata),
        .res_push  (oq_push),
        .res_full  (oq_full)
    );

    lbc_fifo #(.WIDTH($bits(seg_out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_wdata),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata_raw),
        .empty (empty)
    );

    assign result = seg_out_t'(oq_rdata_raw);

    // a transfer into either queue is never attempted while it is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !((mq_push && mq_full) || (oq_push && oq_full)))
        else $error("queue written while full");

    // clipped start point lies inside the window
    a_start_in_win: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.visible) |->
            ($signed(result.clip_start_x) >= $signed(win_reg.x_min) &&
             $signed(result.clip_start_x) <= $signed(win_reg.x_max) &&
             $signed(result.clip_start_y) >= $signed(win_reg.y_min) &&
             $signed(result.clip_start_y) <= $signed(win_reg.y_max)))
        else $error("clipped start point outside window");

    // clipped end point lies inside the window
    a_end_in_win: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.visible) |->
            ($signed(result.clip_end_x) >= $signed(win_reg.x_min) &&
             $signed(result.clip_end_x) <= $signed(win_reg.x_max) &&
             $signed(result.clip_end_y) >= $signed(win_reg.y_min) &&
             $signed(result.clip_end_y) <= $signed(win_reg.y_max)))
        else $error("clipped end point outside window");

    // rejected segments carry zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.visible) |->
            (result.clip_start_x == '0 && result.clip_start_y == '0 &&
             result.clip_end_x == '0 && result.clip_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

endmodule
`default_nettype wire

/* tb/tb_liang_barsky_line_clipper_core.sv */
// Self-checking testbench for the Liang-Barsky line clipper core.
`default_nettype none
module tb_liang_barsky_line_clipper_core
    import lbc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PER_WINDOW = 216;

    typedef struct {
        seg_in_t  seg;
        bit       typed;
        seg_out_t want;
    } seg_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    seg_in_t              segment;
    logic                 empty;
    logic                 pop;
    seg_out_t             result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // typed expectation travels with the segment it belongs to
    logic                 seg_typed;
    seg_out_t             seg_want;

    window_t   win_shadow;
    seg_out_t  pending_clips[$];
    seg_row_t  seg_rows[$];
    int        mismatches;
    int        cycles;
    int        pop_hold;
    bit        steady_pop;

    liang_barsky_line_clipper_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .segment (segment),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // round(base + num/den * delta), ties away from zero
    function automatic longint round_at(longint base, longint num, longint den, longint delta);
        longint t;
        longint m;
        longint qq;
        t  = base * den + num * delta;
        m  = (t < 0) ? -t : t;
        qq = (2 * m + den) / (2 * den);
        return (t < 0) ? -qq : qq;
    endfunction

    function automatic seg_out_t clip_predict(window_t w, seg_in_t s);
        longint x1, y1, dx, dy, n1, d1, n2, d2, rn, rd;
        longint p[4];
        longint q[4];
        bit vis;
        seg_out_t r;
        x1 = longint'(s.start_x);
        y1 = longint'(s.start_y);
        dx = longint'(s.end_x) - x1;
        dy = longint'(s.end_y) - y1;
        n1 = 0; d1 = 1; n2 = 1; d2 = 1;
        vis = 1'b1;
        p[0] = -dx; q[0] = x1 - longint'(w.x_min);
        p[1] = dx;  q[1] = longint'(w.x_max) - x1;
        p[2] = -dy; q[2] = y1 - longint'(w.y_min);
        p[3] = dy;  q[3] = longint'(w.y_max) - y1;
        for (int k = 0; k < 4; k++)
        begin
            if (p[k] == 0)
            begin
                if (q[k] < 0)
                    vis = 1'b0;
            end
            else if (p[k] < 0)
            begin
                rn = -q[k];
                rd = -p[k];
                if (rn * d1 > n1 * rd)
                begin
                    n1 = rn;
                    d1 = rd;
                end
            end
            else
            begin
                rn = q[k];
                rd = p[k];
                if (rn * d2 < n2 * rd)
                begin
                    n2 = rn;
                    d2 = rd;
                end
            end
        end
        if (vis && n1 * d2 > n2 * d1)
            vis = 1'b0;
        r = '0;
        if (vis)
        begin
            r.visible      = 1'b1;
            r.clip_start_x = coord_t'(round_at(x1, n1, d1, dx));
            r.clip_start_y = coord_t'(round_at(y1, n1, d1, dy));
            r.clip_end_x   = coord_t'(round_at(x1, n2, d2, dx));
            r.clip_end_y   = coord_t'(round_at(y1, n2, d2, dy));
        end
        return r;
    endfunction

    function automatic seg_in_t mk_seg(int ax, int ay, int bx, int by);
        seg_in_t s;
        s.start_x = coord_t'(ax);
        s.start_y = coord_t'(ay);
        s.end_x   = coord_t'(bx);
        s.end_y   = coord_t'(by);
        return s;
    endfunction

    function automatic seg_out_t mk_clip(bit v, int ax, int ay, int bx, int by);
        seg_out_t r;
        r.visible      = v;
        r.clip_start_x = coord_t'(ax);
        r.clip_start_y = coord_t'(ay);
        r.clip_end_x   = coord_t'(bx);
        r.clip_end_y   = coord_t'(by);
        return r;
    endfunction

    task automatic add_row(seg_in_t s, bit typed, seg_out_t want);
        seg_row_t row;
        row.seg   = s;
        row.typed = typed;
        row.want  = want;
        seg_rows = {seg_rows, row};
    endtask

    // coordinate near one of the window edges, or anywhere
    function automatic int pick_coord(int lo, int hi);
        int c;
        case ($urandom_range(0, 3))
            0: c = lo + $urandom_range(0, 8) - 4;
            1: c = hi + $urandom_range(0, 8) - 4;
            2: c = lo + $urandom_range(0, 2 * (hi - lo + 8)) - 4;
            default: c = $urandom_range(0, 65535) - 32768;
        endcase
        if (c > 32767)
            c = 32767;
        if (c < -32768)
            c = -32768;
        return c;
    endfunction

    // transfer monitor: predicts on accepted segments, checks accepted results
    always @(posedge clk)
    begin
        seg_out_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_X_MIN: win_shadow.x_min <= coord_t'(pwdata);
                    REG_X_MAX: win_shadow.x_max <= coord_t'(pwdata);
                    REG_Y_MIN: win_shadow.y_min <= coord_t'(pwdata);
                    default:   win_shadow.y_max <= coord_t'(pwdata);
                endcase
            end
            if (push && !full)
                pending_clips = {pending_clips,
                                 seg_typed ? seg_want : clip_predict(win_shadow, segment)};
            if (pop && !empty)
            begin
                if (pending_clips.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", result);
                end
                else
                begin
                    want = pending_clips.pop_front();
                    if (result.visible !== want.visible
                        || result.clip_start_x !== want.clip_start_x
                        || result.clip_start_y !== want.clip_start_y
                        || result.clip_end_x !== want.clip_end_x
                        || result.clip_end_y !== want.clip_end_y)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("clip mismatch: expected %p got %p", want, result);
                    end
                end
            end
        end
    end

    // result side stalls: mostly short, sometimes long, none in steady phases
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop <= 1'b1;
            if (!steady_pop && $urandom_range(0, 7) == 0)
                pop_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_liang_barsky_line_clipper_core failed");
            $finish;
        end
    end

    task automatic send_seg(seg_in_t s, bit typed, seg_out_t want, bit steady);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        segment   <= s;
        seg_typed <= typed;
        seg_want  <= want;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // block idle: nothing pending and the pipeline flushed
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_clips.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_window(int xl, int xh, int yl, int yh);
        wait_drained();
        write_reg(REG_X_MIN, xl);
        write_reg(REG_X_MAX, xh);
        write_reg(REG_Y_MIN, yl);
        write_reg(REG_Y_MAX, yh);
    endtask

    task automatic random_segs(int count, int xl, int xh, int yl, int yh);
        seg_in_t s;
        int ax, ay;
        bit steady;
        steady = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                steady     = ($urandom_range(0, 3) == 0);
                steady_pop = steady;
            end
            ax = pick_coord(xl, xh);
            ay = pick_coord(yl, yh);
            case ($urandom_range(0, 5))
                0: s = mk_seg(ax, ay, ax, ay);
                1: s = mk_seg(ax, ay, ax, pick_coord(yl, yh));
                2: s = mk_seg(ax, ay, pick_coord(xl, xh), ay);
                default: s = mk_seg(ax, ay, pick_coord(xl, xh), pick_coord(yl, yh));
            endcase
            send_seg(s, 1'b0, '0, steady);
        end
        steady_pop = 1'b0;
    endtask

    initial
    begin
        int xl, xh, yl, yh;
        rst_n      = 1'b0;
        push       = 1'b0;
        segment    = '0;
        seg_typed  = 1'b0;
        seg_want   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        cycles     = 0;
        pop_hold   = 0;
        steady_pop = 1'b0;
        win_shadow.x_min = 16'sd0;
        win_shadow.x_max = 16'sd1023;
        win_shadow.y_min = 16'sd0;
        win_shadow.y_max = 16'sd1023;

        // reset window 0..1023 on both axes
        add_row(mk_seg(10, 20, 100, 200), 1, mk_clip(1, 10, 20, 100, 200));
        add_row(mk_seg(-5, -5, -5, -5), 1, mk_clip(0, 0, 0, 0, 0));
        add_row(mk_seg(0, 0, 0, 0), 1, mk_clip(1, 0, 0, 0, 0));
        add_row(mk_seg(1023, 1023, 1023, 1023), 1, mk_clip(1, 1023, 1023, 1023, 1023));
        add_row(mk_seg(1024, 5, 1024, 5), 1, mk_clip(0, 0, 0, 0, 0));
        add_row(mk_seg(-10, 5, -10, 500), 1, mk_clip(0, 0, 0, 0, 0));
        add_row(mk_seg(5, 1100, 900, 1100), 1, mk_clip(0, 0, 0, 0, 0));
        add_row(mk_seg(-100, 500, 2000, 500), 1, mk_clip(1, 0, 500, 1023, 500));
        add_row(mk_seg(2000, 500, -100, 500), 1, mk_clip(1, 1023, 500, 0, 500));
        add_row(mk_seg(300, -50, 300, 5000), 1, mk_clip(1, 300, 0, 300, 1023));
        add_row(mk_seg(-32768, -32768, 32767, 32767), 0, '0);
        add_row(mk_seg(32767, -32768, -32768, 32767), 0, '0);
        add_row(mk_seg(-32768, 32767, 32767, -32768), 0, '0);
        add_row(mk_seg(32767, 32767, -32768, -32768), 0, '0);
        add_row(mk_seg(-100, 1200, 1200, 2000), 0, '0);
        add_row(mk_seg(-1, 3, 2, 1030), 0, '0);
        add_row(mk_seg(-3, 1, 1030, 2), 0, '0);
        add_row(mk_seg(-500, 900, 600, -400), 0, '0);
        add_row(mk_seg(1500, 1500, 2000, 2000), 1, mk_clip(0, 0, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (seg_rows[i])
            send_seg(seg_rows[i].seg, seg_rows[i].typed, seg_rows[i].want, 1'b0);
        push      <= 1'b0;
        seg_typed <= 1'b0;
        @(posedge clk);
        random_segs(RANDOM_PER_WINDOW, 0, 1023, 0, 1023);

        // full coordinate range
        set_window(-32768, 32767, -32768, 32767);
        random_segs(RANDOM_PER_WINDOW, -32768, 32767, -32768, 32767);

        // single-point window
        set_window(7, 7, -9, -9);
        random_segs(RANDOM_PER_WINDOW / 2, 7, 7, -9, -9);

        // inverted window rejects everything
        set_window(500, -500, 100, -100);
        send_seg(mk_seg(0, 0, 0, 0), 1, mk_clip(0, 0, 0, 0, 0), 1'b0);
        push <= 1'b0;
        @(posedge clk);
        random_segs(RANDOM_PER_WINDOW / 2, -500, 500, -100, 100);

        // small window at the negative corner
        set_window(-32768, -32700, -32768, -32760);
        random_segs(RANDOM_PER_WINDOW / 2, -32768, -32700, -32768, -32760);

        repeat (3)
        begin
            xl = $urandom_range(0, 65535) - 32768;
            xh = $urandom_range(xl + 32768, 65535) - 32768;
            yl = $urandom_range(0, 65535) - 32768;
            yh = $urandom_range(yl + 32768, 65535) - 32768;
            set_window(xl, xh, yl, yh);
            random_segs(RANDOM_PER_WINDOW / 2, xl, xh, yl, yh);
        end

        wait_drained();
        if (mismatches == 0 && pending_clips.size() == 0)
            $display("tb_liang_barsky_line_clipper_core passed");
        else
            $display("tb_liang_barsky_line_clipper_core failed");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/lbc_pkg.sv
rtl/lbc_fifo.sv
rtl/lbc_front.sv
rtl/lbc_coord.sv
rtl/lbc_back.sv
rtl/liang_barsky_line_clipper_core.sv
tb/tb_liang_barsky_line_clipper_core.sv
